>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the canonical code block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define CHC_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define CHC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> src/chca_pkg.sv
// Shared widths, defaults and types of the canonical Huffman code block.
package chca_pkg;

   localparam int SYMBOL_COUNT_DEF = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   localparam int SYM_W  = 8;
   localparam int LEN_W  = 6;
   localparam int CODE_W = 32;

   // Operands of one canonical code step.
   typedef struct packed {
      logic [CODE_W-1:0] prev_code;
      logic [LEN_W-1:0]  prev_len;
      logic [LEN_W-1:0]  cur_len;
   } code_req_type;

   // Code value and overflow flag that come back from the step.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              overflow;
   } code_rsp_type;

endpackage

>>> src/chca_code_gen.sv
// Next canonical code from the previous code and the increase in length; zero for the first code.
module chca_code_gen (
   input  chca_pkg::code_req_type req,
   output chca_pkg::code_rsp_type rsp
);
   import chca_pkg::*;

   logic              first_code;
   logic [CODE_W:0]   incr;
   logic [LEN_W-1:0]  len_step;
   logic [CODE_W-1:0] shifted;
   logic [CODE_W-1:0] len_mask;

   assign first_code = (req.prev_len == '0);
   assign incr       = {1'b0, req.prev_code} + {{CODE_W{1'b0}}, 1'b1};
   assign len_step   = req.cur_len - req.prev_len;
   assign shifted    = incr[CODE_W-1:0] << len_step;
   // A shift by the full width leaves zero, so the mask becomes all ones.
   assign len_mask   = ~({CODE_W{1'b1}} << req.cur_len);

   always_comb begin
      if (first_code) begin
         rsp.code     = '0;
         rsp.overflow = 1'b0;
      end else begin
         rsp.code     = shifted & len_mask;
         rsp.overflow = ((incr >> req.prev_len) != '0);
      end
   end

endmodule

>>> src/canonical_huffman_code_assign.sv
// Top level of the canonical Huffman code assignment block.
//
// Requests arrive on the req_ channel (valid/ready) and every request gives
// exactly one transfer on the rsp_ channel (valid/ready). A load writes one
// symbol's code length into the length table, a clear empties the table, and
// a fetch returns the next symbol in canonical order with its code.
// Loads, clears and the unused mode go from idle straight to the emit state.
// A fetch sweeps the length memory once, one symbol a cycle through its single
// read port, and stops early when it meets the next symbol at the current
// length; a fetch with no entries left skips the sweep and answers empty.
// One request is worked on at a time; req_ready is high while the block waits
// for work. The next request is taken once the response is loaded, so a
// request never starts before the one ahead of it has its response. A finished
// response sits in the output register, so a new request is taken while the
// receiver stalls; the response after it waits its turn.
// Reset empties the table at once through per-symbol presence bits, ends any
// fetch sequence and drops a pending response.
module canonical_huffman_code_assign #(
   parameter int SYMBOL_COUNT = chca_pkg::SYMBOL_COUNT_DEF,
   parameter int MAX_CODE_LEN = chca_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic [chca_pkg::SYM_W-1:0]  req_symbol,
   input  logic [chca_pkg::LEN_W-1:0]  req_code_length,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_valid_res,
   output logic [chca_pkg::SYM_W-1:0]  rsp_out_symbol,
   output logic [chca_pkg::LEN_W-1:0]  rsp_out_length,
   output logic [chca_pkg::CODE_W-1:0] rsp_code,
   output logic                        rsp_last,
   output logic                        rsp_overflow
);
   import chca_pkg::*;

   localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int CNT_W = $clog2(SYMBOL_COUNT + 1);

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_FETCH = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Length table: one synchronous memory, presence bits in flip-flops.
   logic [LEN_W-1:0]        length_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] present_ff, present_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [LEN_W-1:0]        len_sat;

   // Fetch sequence state.
   logic                    started_ff, started_in;
   logic [LEN_W-1:0]        cur_len_ff, cur_len_in;
   logic [CNT_W-1:0]        cur_sym_ff, cur_sym_in;
   logic [CODE_W-1:0]       prev_code_ff, prev_code_in;
   logic [LEN_W-1:0]        prev_len_ff, prev_len_in;
   logic [CNT_W-1:0]        entries_left_ff, entries_left_in;
   logic [CNT_W-1:0]        left_eff;

   // Sweep over the memory.
   logic [IDX_W-1:0]        scan_addr_ff, scan_addr_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]        rd_sym_ff;
   logic [LEN_W-1:0]        rd_len_ff;
   logic                    rd_pres_ff;
   logic                    best_found_ff, best_found_in;
   logic [IDX_W-1:0]        best_sym_ff, best_sym_in;
   logic [LEN_W-1:0]        best_len_ff, best_len_in;
   logic                    proc, cand, take, hit, scan_end;

   // Response being built, then the output register.
   logic                    res_valid_ff, res_valid_in;
   logic [SYM_W-1:0]        res_symbol_ff, res_symbol_in;
   logic [LEN_W-1:0]        res_length_ff, res_length_in;
   logic [CODE_W-1:0]       res_code_ff, res_code_in;
   logic                    res_last_ff, res_last_in;
   logic                    res_ovf_ff, res_ovf_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   logic                    rsp_valid_res_ff;
   logic [SYM_W-1:0]        rsp_symbol_ff;
   logic [LEN_W-1:0]        rsp_length_ff;
   logic [CODE_W-1:0]       rsp_code_ff;
   logic                    rsp_last_ff;
   logic                    rsp_ovf_ff;

   code_req_type            gen_req;
   code_rsp_type            gen_rsp;

   logic                    req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign len_sat = (req_code_length > LEN_W'(MAX_CODE_LEN)) ?
                    LEN_W'(MAX_CODE_LEN) : req_code_length;
   assign mem_waddr = req_symbol[IDX_W-1:0];
   assign mem_we    = req_take && (req_mode == MODE_LOAD) &&
                      (32'(req_symbol) < SYMBOL_COUNT);

   assign left_eff = started_ff ? entries_left_ff : count_ff;

   // A symbol qualifies when it comes at or after the cursor in canonical
   // order; the smallest length wins, and among equal lengths the first seen.
   assign proc     = rd_valid_ff && ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN));
   assign cand     = rd_pres_ff && ((rd_len_ff > cur_len_ff) ||
                     ((rd_len_ff == cur_len_ff) && (CNT_W'(rd_sym_ff) >= cur_sym_ff)));
   assign take     = proc && cand && (!best_found_ff || (rd_len_ff < best_len_ff));
   assign hit      = proc && cand && (rd_len_ff == cur_len_ff);
   assign scan_end = (scan_addr_ff == IDX_W'(SYMBOL_COUNT - 1));

   assign gen_req.prev_code = prev_code_ff;
   assign gen_req.prev_len  = prev_len_ff;
   assign gen_req.cur_len   = best_len_ff;

   chca_code_gen u_code_gen (
      .req (gen_req),
      .rsp (gen_rsp)
   );

   assign rsp_load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      state_in        = state_ff;
      present_in      = present_ff;
      count_in        = count_ff;
      started_in      = started_ff;
      cur_len_in      = cur_len_ff;
      cur_sym_in      = cur_sym_ff;
      prev_code_in    = prev_code_ff;
      prev_len_in     = prev_len_ff;
      entries_left_in = entries_left_ff;
      scan_addr_in    = scan_addr_ff;
      rd_valid_in     = 1'b0;
      best_found_in   = best_found_ff;
      best_sym_in     = best_sym_ff;
      best_len_in     = best_len_ff;
      res_valid_in    = res_valid_ff;
      res_symbol_in   = res_symbol_ff;
      res_length_in   = res_length_ff;
      res_code_in     = res_code_ff;
      res_last_in     = res_last_ff;
      res_ovf_in      = res_ovf_ff;

      if (take) begin
         best_found_in = 1'b1;
         best_sym_in   = rd_sym_ff;
         best_len_in   = rd_len_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_valid_in  = 1'b0;
               res_symbol_in = '0;
               res_length_in = '0;
               res_code_in   = '0;
               res_last_in   = 1'b0;
               res_ovf_in    = 1'b0;
               state_in      = ST_EMIT;
               unique case (req_mode)
                  MODE_LOAD: begin
                     started_in = 1'b0;
                     if (mem_we) begin
                        present_in[mem_waddr] = (len_sat != '0);
                        count_in = count_ff - CNT_W'(present_ff[mem_waddr])
                                 + CNT_W'(len_sat != '0);
                     end
                  end
                  MODE_CLEAR: begin
                     started_in      = 1'b0;
                     present_in      = '0;
                     count_in        = '0;
                     entries_left_in = '0;
                  end
                  MODE_FETCH: begin
                     if (!started_ff) begin
                        started_in      = 1'b1;
                        entries_left_in = count_ff;
                        cur_len_in      = LEN_W'(1);
                        cur_sym_in      = '0;
                        prev_code_in    = '0;
                        prev_len_in     = '0;
                     end
                     if (left_eff != '0) begin
                        state_in      = ST_SCAN;
                        scan_addr_in  = '0;
                        best_found_in = 1'b0;
                     end
                  end
                  default: begin
                     // The unused mode answers with an empty response.
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_valid_in  = 1'b1;
            scan_addr_in = scan_addr_ff + IDX_W'(1);
            if (hit) begin
               state_in = ST_FINISH;
            end else if (scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_EMIT;
            if (!best_found_ff) begin
               entries_left_in = '0;
            end else begin
               entries_left_in = entries_left_ff - CNT_W'(1);
               prev_code_in    = gen_rsp.code;
               prev_len_in     = best_len_ff;
               cur_len_in      = best_len_ff;
               cur_sym_in      = CNT_W'(best_sym_ff) + CNT_W'(1);
               res_valid_in    = 1'b1;
               res_symbol_in   = SYM_W'(best_sym_ff);
               res_length_in   = best_len_ff;
               res_code_in     = gen_rsp.code;
               res_last_in     = (entries_left_ff == CNT_W'(1));
               res_ovf_in      = gen_rsp.overflow;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Length memory: written by loads, read one symbol a cycle by the sweep.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         length_mem[mem_waddr] <= len_sat;
      end
      rd_len_ff <= length_mem[scan_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         present_ff      <= '0;
         count_ff        <= '0;
         started_ff      <= 1'b0;
         cur_len_ff      <= '0;
         cur_sym_ff      <= '0;
         prev_code_ff    <= '0;
         prev_len_ff     <= '0;
         entries_left_ff <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         present_ff      <= present_in;
         count_ff        <= count_in;
         started_ff      <= started_in;
         cur_len_ff      <= cur_len_in;
         cur_sym_ff      <= cur_sym_in;
         prev_code_ff    <= prev_code_in;
         prev_len_ff     <= prev_len_in;
         entries_left_ff <= entries_left_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      rd_sym_ff     <= scan_addr_ff;
      rd_pres_ff    <= present_ff[scan_addr_ff];
      best_found_ff <= best_found_in;
      best_sym_ff   <= best_sym_in;
      best_len_ff   <= best_len_in;
      res_valid_ff  <= res_valid_in;
      res_symbol_ff <= res_symbol_in;
      res_length_ff <= res_length_in;
      res_code_ff   <= res_code_in;
      res_last_ff   <= res_last_in;
      res_ovf_ff    <= res_ovf_in;
      if (rsp_load) begin
         rsp_valid_res_ff <= res_valid_ff;
         rsp_symbol_ff    <= res_symbol_ff;
         rsp_length_ff    <= res_length_ff;
         rsp_code_ff      <= res_code_ff;
         rsp_last_ff      <= res_last_ff;
         rsp_ovf_ff       <= res_ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_res  = rsp_valid_res_ff;
   assign rsp_out_symbol = rsp_symbol_ff;
   assign rsp_out_length = rsp_length_ff;
   assign rsp_code       = rsp_code_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;

`include "assert_macros.svh"

   // The running symbol count must track the presence bits exactly.
   `CHC_ASSERT_ALWAYS(a_count_matches, count_ff == CNT_W'($countones(present_ff)),
                      "symbol count out of step with presence bits")
   // A fetch sequence never has more entries left than symbols present.
   `CHC_ASSERT_IMPLIES(a_left_bounded, started_ff, entries_left_ff <= count_ff,
                       "entries left exceed table population")
   // The final-entry flag only comes with a returned entry.
   `CHC_ASSERT_IMPLIES(a_last_needs_entry, rsp_valid && rsp_last, rsp_valid_res,
                       "last flag on an empty response")
   // A fetch result is only built after the sweep has drained or hit.
   `CHC_ASSERT_IMPLIES(a_finish_order, state_ff == ST_FINISH,
                       $past(state_ff) == ST_SCAN || $past(state_ff) == ST_DRAIN,
                       "finish entered without a sweep")

endmodule
